[hw/rtl/kmn_pkg.sv]
package kmn_pkg;

    localparam int COORD_FIELDS  = 8;
    localparam int COORD_FIELD_W = 16;
    localparam int SLOT_W        = 3;
    localparam int INDEX_W       = 3;
    localparam int DIST_W        = 35;
    localparam int MASK_W        = 8;
    localparam int COUNT_W       = 4;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_DIMENSION_MASK = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLUSTER_COUNT  = 1'b1;

    localparam logic OP_LOAD     = 1'b0;
    localparam logic OP_CLASSIFY = 1'b1;

    localparam logic [MASK_W-1:0]  MASK_RESET  = 8'hff;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 4'd8;

    typedef struct packed {
        logic                            op;
        logic [SLOT_W-1:0]               centroid_slot;
        logic signed [COORD_FIELD_W-1:0] coord_0;
        logic signed [COORD_FIELD_W-1:0] coord_1;
        logic signed [COORD_FIELD_W-1:0] coord_2;
        logic signed [COORD_FIELD_W-1:0] coord_3;
        logic signed [COORD_FIELD_W-1:0] coord_4;
        logic signed [COORD_FIELD_W-1:0] coord_5;
        logic signed [COORD_FIELD_W-1:0] coord_6;
        logic signed [COORD_FIELD_W-1:0] coord_7;
    } t_in_item;

    typedef struct packed {
        logic [INDEX_W-1:0] cluster_index;
        logic [DIST_W-1:0]  squared_distance;
    } t_out_item;

    // one squared-difference step travelling down the datapath
    typedef struct packed {
        logic valid;
        logic first;   // first dimension of a centroid
        logic last;    // last dimension of a centroid
        logic final_c; // last dimension of the last centroid
        logic active;  // dimension enabled in the mask
    } t_tag;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SCAN,
        ST_DRAIN,
        ST_PUSH
    } t_state;

endpackage

[hw/rtl/kmn_stream_if.sv]
interface kmn_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/kmn_store.sv]
module kmn_store
    import kmn_pkg::*;
#(
    parameter int DEPTH   = 64,
    parameter int ADDR_W  = 6,
    parameter int COORD_W = 16
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [ADDR_W-1:0]  i_addr,
    input  logic [COORD_W-1:0] i_wdata,
    output logic [COORD_W-1:0] o_rdata
);

    logic [COORD_W-1:0] r_mem [DEPTH];
    logic [COORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/kmn_sqdiff.sv]
module kmn_sqdiff
    import kmn_pkg::*;
#(
    parameter int COORD_W = 16,
    parameter int SQ_W    = 33
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_tag                      i_tag,
    input  logic signed [COORD_W-1:0] i_a,
    input  logic signed [COORD_W-1:0] i_b,
    output t_tag                      o_tag,
    output logic [SQ_W-1:0]           o_sq
);

    logic signed [COORD_W:0]     w_diff;
    logic signed [2*COORD_W+1:0] w_prod;
    t_tag                        r_tag;
    logic [SQ_W-1:0]             r_sq;

    assign w_diff = (COORD_W+1)'(i_a) - (COORD_W+1)'(i_b);
    assign w_prod = w_diff * w_diff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= '0;
        end else begin
            r_tag <= i_tag;
        end
        // masked-off dimensions contribute nothing
        r_sq <= i_tag.active ? w_prod[SQ_W-1:0] : '0;
    end

    assign o_tag = r_tag;
    assign o_sq  = r_sq;

endmodule

[hw/rtl/kmn_accum.sv]
module kmn_accum
    import kmn_pkg::*;
#(
    parameter int SQ_W  = 33,
    parameter int ACC_W = 36,
    parameter int CI_W  = 3
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_tag              i_tag,
    input  logic [SQ_W-1:0]   i_sq,
    output logic              o_done,
    output logic [CI_W-1:0]   o_best_idx,
    output logic [ACC_W-1:0]  o_best_dist
);

    t_tag             r_tag;
    logic [ACC_W-1:0] r_acc;
    logic [CI_W-1:0]  r_cmp_c;
    logic [CI_W-1:0]  r_best_idx;
    logic [ACC_W-1:0] r_best_dist;
    logic             r_done;
    logic             w_take;

    // strict less keeps the lower index on ties
    assign w_take = (r_cmp_c == '0) || (r_acc < r_best_dist);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag   <= '0;
            r_cmp_c <= '0;
            r_done  <= 1'b0;
        end else begin
            r_tag  <= i_tag;
            r_done <= r_tag.valid && r_tag.last && r_tag.final_c;
            if (r_tag.valid && r_tag.last) begin
                r_cmp_c <= r_tag.final_c ? '0 : CI_W'(r_cmp_c + 1'b1);
            end
        end
        if (i_tag.valid) begin
            r_acc <= i_tag.first ? ACC_W'(i_sq) : r_acc + ACC_W'(i_sq);
        end
        if (r_tag.valid && r_tag.last && w_take) begin
            r_best_idx  <= r_cmp_c;
            r_best_dist <= r_acc;
        end
    end

    assign o_done      = r_done;
    assign o_best_idx  = r_best_idx;
    assign o_best_dist = r_best_dist;

endmodule

[hw/rtl/kmn_ctrl.sv]
module kmn_ctrl
    import kmn_pkg::*;
#(
    parameter int MAX_CLUSTERS = 8,
    parameter int DIMENSIONS   = 8,
    parameter int D_ACT        = 8,
    parameter int CI_W         = 3,
    parameter int DI_W         = 3,
    parameter int ADDR_W       = 6
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_op,
    input  logic [SLOT_W-1:0]  i_slot,
    input  logic [COUNT_W-1:0] i_count,
    input  logic [MASK_W-1:0]  i_mask,
    input  logic               i_acc_done,
    input  logic               i_out_free,
    output logic               o_in_ready,
    output logic               o_we,
    output logic [ADDR_W-1:0]  o_addr,
    output logic [DI_W-1:0]    o_dim,
    output t_tag               o_tag,
    output logic               o_push
);

    t_state          r_state;
    t_state          n_state;
    logic [CI_W-1:0] r_c;
    logic [DI_W-1:0] r_d;
    logic [CI_W-1:0] r_last_c;
    logic            w_accept;
    logic            w_slot_ok;
    logic            w_last_d;
    logic            w_last_c;
    logic [CI_W-1:0] w_last_c_cfg;

    assign w_accept  = i_in_valid && (r_state == ST_IDLE);
    assign w_slot_ok = int'(i_slot) < MAX_CLUSTERS;
    assign w_last_d  = r_d == DI_W'(D_ACT - 1);
    assign w_last_c  = r_c == r_last_c;

    // zero counts as one, anything above the store size saturates
    always_comb begin
        if (i_count == '0) begin
            w_last_c_cfg = '0;
        end else if (int'(i_count) > MAX_CLUSTERS) begin
            w_last_c_cfg = CI_W'(MAX_CLUSTERS - 1);
        end else begin
            w_last_c_cfg = CI_W'(i_count - 1'b1);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_op == OP_CLASSIFY) begin
                        n_state = ST_SCAN;
                    end else if (w_slot_ok) begin
                        n_state = ST_LOAD;
                    end
                end
            end
            ST_LOAD: begin
                if (w_last_d) begin
                    n_state = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (w_last_d && w_last_c) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (i_acc_done) begin
                    n_state = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready    = 1'b0;
        o_we          = 1'b0;
        o_push        = 1'b0;
        o_tag         = '0;
        unique case (r_state)
            ST_IDLE:  o_in_ready = 1'b1;
            ST_LOAD:  o_we = 1'b1;
            ST_SCAN: begin
                o_tag.valid   = 1'b1;
                o_tag.first   = r_d == '0;
                o_tag.last    = w_last_d;
                o_tag.final_c = w_last_d && w_last_c;
                o_tag.active  = i_mask[r_d];
            end
            ST_DRAIN: ;
            ST_PUSH:  o_push = i_out_free;
            default: ;
        endcase
    end

    assign o_addr = ADDR_W'(r_c) * ADDR_W'(DIMENSIONS) + ADDR_W'(r_d);
    assign o_dim  = r_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_d      <= '0;
                r_c      <= (i_op == OP_LOAD) ? CI_W'(i_slot) : '0;
                r_last_c <= w_last_c_cfg;
            end
            ST_LOAD, ST_SCAN: begin
                if (w_last_d) begin
                    r_d <= '0;
                    r_c <= CI_W'(r_c + 1'b1);
                end else begin
                    r_d <= DI_W'(r_d + 1'b1);
                end
            end
            default: ;
        endcase
    end

endmodule

[hw/rtl/kmeans_nearest_centroid_assign_core.sv]
// nearest-centroid assignment for k-means
//
// i_in (valid/ready) takes one beat per item. op load writes the eight
// coordinates into the centroid slot given; op classify compares the point
// with centroids 0 .. cluster_count-1 and returns one beat on o_out with the
// nearest index (lower index wins ties) and the masked squared distance.
// i_cfg_we/i_cfg_index/i_cfg_data write the dimension mask (index 0) and
// the cluster count (index 1); write only while the block is idle.
//
// one squared-difference unit is shared: one dimension of one centroid per
// cycle, so a classify beat scans each dimension of each centroid in turn;
// the store read, the squared difference, the accumulator and the best
// compare are registered in turn, and i_in is ready again once the result
// is registered. a load beat writes min(DIMENSIONS, 8) words, one per cycle.
// the result sits in an output register; a stalled receiver only holds back
// the next classify once it finishes. reset clears control and sets the mask
// to all ones and the count to 8; the centroid store is not cleared and must
// be loaded before use.
module kmeans_nearest_centroid_assign_core
    import kmn_pkg::*;
#(
    parameter int MAX_CLUSTERS = 8,
    parameter int DIMENSIONS   = 8,
    parameter int COORD_WIDTH  = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    kmn_stream_if.sink            i_in,
    kmn_stream_if.source          o_out
);

    localparam int D_ACT  = (DIMENSIONS < COORD_FIELDS) ? DIMENSIONS : COORD_FIELDS;
    localparam int DEPTH  = MAX_CLUSTERS * DIMENSIONS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CI_W   = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
    localparam int DI_W   = (D_ACT > 1) ? $clog2(D_ACT) : 1;
    localparam int SQ_W   = 2 * COORD_WIDTH + 1;
    localparam int ACC_W  = SQ_W + 3;

    logic [MASK_W-1:0]      r_mask;
    logic [COUNT_W-1:0]     r_count;
    logic [COORD_WIDTH-1:0] r_point [D_ACT];
    logic [COORD_FIELD_W-1:0] w_raw [COORD_FIELDS];
    logic [COORD_WIDTH-1:0] w_coord [D_ACT];
    t_in_item               w_in;
    logic                   w_in_ready;
    logic                   w_accept;

    logic                   w_we;
    logic [ADDR_W-1:0]      w_addr;
    logic [DI_W-1:0]        w_dim;
    t_tag                   w_issue;
    logic                   w_push;
    logic [COORD_WIDTH-1:0] w_rdata;

    t_tag                   r_tag_a;
    logic [COORD_WIDTH-1:0] r_pa;
    t_tag                   w_tag_b;
    logic [SQ_W-1:0]        w_sq;
    logic                   w_acc_done;
    logic [CI_W-1:0]        w_best_idx;
    logic [ACC_W-1:0]       w_best_dist;

    logic                   r_out_valid;
    t_out_item              r_out;
    logic                   w_out_free;

    assign w_in     = i_in.data;
    assign w_accept = i_in.valid && w_in_ready;
    assign i_in.ready = w_in_ready;

    assign w_raw[0] = w_in.coord_0;
    assign w_raw[1] = w_in.coord_1;
    assign w_raw[2] = w_in.coord_2;
    assign w_raw[3] = w_in.coord_3;
    assign w_raw[4] = w_in.coord_4;
    assign w_raw[5] = w_in.coord_5;
    assign w_raw[6] = w_in.coord_6;
    assign w_raw[7] = w_in.coord_7;

    // low COORD_WIDTH bits of the field, field bits zero-extended when narrower
    always_comb begin
        logic [COORD_FIELD_W+COORD_WIDTH-1:0] ext;
        for (int i = 0; i < D_ACT; i++) begin
            ext        = {{COORD_WIDTH{1'b0}}, w_raw[i]};
            w_coord[i] = ext[COORD_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            for (int i = 0; i < D_ACT; i++) begin
                r_point[i] <= w_coord[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask  <= MASK_RESET;
            r_count <= COUNT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DIMENSION_MASK: r_mask  <= i_cfg_data[MASK_W-1:0];
                CFG_CLUSTER_COUNT:  r_count <= i_cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    kmn_ctrl #(
        .MAX_CLUSTERS (MAX_CLUSTERS),
        .DIMENSIONS   (DIMENSIONS),
        .D_ACT        (D_ACT),
        .CI_W         (CI_W),
        .DI_W         (DI_W),
        .ADDR_W       (ADDR_W)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_op       (w_in.op),
        .i_slot     (w_in.centroid_slot),
        .i_count    (r_count),
        .i_mask     (r_mask),
        .i_acc_done (w_acc_done),
        .i_out_free (w_out_free),
        .o_in_ready (w_in_ready),
        .o_we       (w_we),
        .o_addr     (w_addr),
        .o_dim      (w_dim),
        .o_tag      (w_issue),
        .o_push     (w_push)
    );

    kmn_store #(
        .DEPTH   (DEPTH),
        .ADDR_W  (ADDR_W),
        .COORD_W (COORD_WIDTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_addr  (w_addr),
        .i_wdata (r_point[w_dim]),
        .o_rdata (w_rdata)
    );

    // point coordinate lines up with the registered store read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_a <= '0;
        end else begin
            r_tag_a <= w_issue;
        end
        r_pa <= r_point[w_dim];
    end

    kmn_sqdiff #(
        .COORD_W (COORD_WIDTH),
        .SQ_W    (SQ_W)
    ) u_sqdiff (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (r_tag_a),
        .i_a     (r_pa),
        .i_b     (w_rdata),
        .o_tag   (w_tag_b),
        .o_sq    (w_sq)
    );

    kmn_accum #(
        .SQ_W  (SQ_W),
        .ACC_W (ACC_W),
        .CI_W  (CI_W)
    ) u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tag       (w_tag_b),
        .i_sq        (w_sq),
        .o_done      (w_acc_done),
        .o_best_idx  (w_best_idx),
        .o_best_dist (w_best_dist)
    );

    assign w_out_free = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_push) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_push) begin
            r_out.cluster_index    <= INDEX_W'(w_best_idx);
            r_out.squared_distance <= DIST_W'(w_best_dist);
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

endmodule

[tb/sv/kmeans_nearest_centroid_assign_core_test.sv]
module kmeans_nearest_centroid_assign_core_test;
    import kmn_pkg::*;

    localparam int CENTROID_SLOTS  = 1 << SLOT_W;
    localparam int COORD_BITS      = COORD_FIELDS * COORD_FIELD_W;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int HOLD_CYCLES     = 400;
    localparam int SETTLE_CYCLES   = 24;
    localparam int DRAIN_LIMIT     = 50000;
    localparam int TIMEOUT_CYCLES  = 1000000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    kmn_stream_if #(.T(t_in_item))  in_bus ();
    kmn_stream_if #(.T(t_out_item)) out_bus ();

    kmeans_nearest_centroid_assign_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in        (in_bus.sink),
        .o_out       (out_bus.source)
    );

    // predictor state, updated as beats are accepted
    logic signed [COORD_FIELD_W-1:0] centroid_mem [CENTROID_SLOTS][COORD_FIELDS];
    logic [MASK_W-1:0]               mask_reg;
    logic [COUNT_W-1:0]              count_reg;

    t_in_item    pending_items [$];
    t_out_item   nearest_expected [$];
    t_in_item    beat_in;
    t_out_item   want;

    int unsigned sender_idle_pct;
    int unsigned receiver_idle_pct;
    logic        hold_off;
    int          mismatch_count;
    int          load_beats;
    int          classify_beats;
    int          results_checked;
    int          settings_used;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic int coord_lsb(int d);
        return (COORD_FIELDS - 1 - d) * COORD_FIELD_W;
    endfunction

    function automatic t_out_item nearest_centroid(t_in_item it);
        t_out_item res;
        int        n;
        longint    acc;
        longint    best;
        longint    diff;
        n = (count_reg == 0) ? 1 :
            ((count_reg > CENTROID_SLOTS) ? CENTROID_SLOTS : int'(count_reg));
        best = 0;
        res  = '0;
        for (int c = 0; c < n; c++) begin
            acc = 0;
            for (int d = 0; d < COORD_FIELDS; d++) begin
                if (mask_reg[d]) begin
                    diff = longint'($signed(it[coord_lsb(d) +: COORD_FIELD_W]))
                         - longint'(centroid_mem[c][d]);
                    acc += diff * diff;
                end
            end
            // strict compare keeps the lower index on a tie
            if (c == 0 || acc < best) begin
                best = acc;
                res.cluster_index = c[INDEX_W-1:0];
            end
        end
        res.squared_distance = best[DIST_W-1:0];
        return res;
    endfunction

    function automatic logic [COORD_BITS-1:0] make_coords(int style);
        logic [COORD_BITS-1:0]    flat;
        logic [COORD_FIELD_W-1:0] v;
        int                       anchor;
        anchor = $urandom_range(CENTROID_SLOTS - 1);
        for (int d = 0; d < COORD_FIELDS; d++) begin
            case (style)
                0: v = COORD_FIELD_W'($urandom);
                1: begin
                    // tiny values so that ties between centroids show up
                    v = COORD_FIELD_W'($urandom_range(6));
                    v = v - COORD_FIELD_W'(3);
                end
                2: begin
                    case ($urandom_range(3))
                        0: v = 16'h7fff;
                        1: v = 16'h8000;
                        2: v = '0;
                        default: v = COORD_FIELD_W'($urandom);
                    endcase
                end
                default: begin
                    v = centroid_mem[anchor][d];
                    v = COORD_FIELD_W'(v + $urandom_range(2) - 1);
                end
            endcase
            flat[coord_lsb(d) +: COORD_FIELD_W] = v;
        end
        return flat;
    endfunction

    task automatic queue_item(logic op, logic [SLOT_W-1:0] slot, logic [COORD_BITS-1:0] coords);
        pending_items.insert(pending_items.size(), t_in_item'({op, slot, coords}));
    endtask

    task automatic report_mismatch(string what);
        $display("mismatch at %0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        if (idx == CFG_DIMENSION_MASK) begin
            mask_reg = val[MASK_W-1:0];
        end else begin
            count_reg = val[COUNT_W-1:0];
        end
    endtask

    task automatic apply_settings(logic [MASK_W-1:0] mask, logic [COUNT_W-1:0] count);
        write_reg(CFG_DIMENSION_MASK, CFG_DATA_W'(mask));
        write_reg(CFG_CLUSTER_COUNT, CFG_DATA_W'(count));
        settings_used++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        int   waited;
        logic busy;
        waited = 0;
        busy   = 1'b1;
        while (busy && waited < DRAIN_LIMIT) begin
            @(negedge i_clk);
            waited++;
            busy = pending_items.size() != 0 || in_bus.valid || nearest_expected.size() != 0;
        end
        if (busy) begin
            report_mismatch($sformatf("%0d results never arrived", nearest_expected.size()));
            nearest_expected.delete();
        end
        // a trailing load may still be writing the store
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic run_random_phase(logic [MASK_W-1:0] mask, logic [COUNT_W-1:0] count,
                                    int unsigned send_idle, int unsigned recv_idle,
                                    logic with_hold);
        int style;
        apply_settings(mask, count);
        sender_idle_pct   = send_idle;
        receiver_idle_pct = recv_idle;
        if (with_hold) begin
            fork
                begin
                    hold_off <= 1'b1;
                    repeat (HOLD_CYCLES) @(posedge i_clk);
                    hold_off <= 1'b0;
                end
            join_none
        end
        repeat (ITEMS_PER_PHASE) begin
            style = $urandom_range(3);
            queue_item($urandom_range(99) < 25 ? OP_LOAD : OP_CLASSIFY, SLOT_W'($urandom),
                       make_coords(style));
        end
        wait_drained();
    endtask

    // driver: holds a beat until taken, then moves to the next pending one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_bus.valid <= 1'b0;
        end else begin
            if (in_bus.valid && in_bus.ready) begin
                beat_in = in_bus.data;
                if (beat_in.op == OP_LOAD) begin
                    for (int d = 0; d < COORD_FIELDS; d++) begin
                        centroid_mem[beat_in.centroid_slot][d] =
                            beat_in[coord_lsb(d) +: COORD_FIELD_W];
                    end
                    load_beats++;
                end else begin
                    nearest_expected.insert(nearest_expected.size(),
                                            nearest_centroid(beat_in));
                    classify_beats++;
                end
            end
            if (!in_bus.valid || in_bus.ready) begin
                if (pending_items.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    in_bus.valid <= 1'b1;
                    in_bus.data  <= pending_items.pop_front();
                end else begin
                    in_bus.valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_bus.ready <= 1'b0;
        end else begin
            out_bus.ready <= !hold_off && ($urandom_range(99) >= receiver_idle_pct);
            if (out_bus.valid && out_bus.ready) begin
                if (nearest_expected.size() == 0) begin
                    report_mismatch("result beat with nothing expected");
                end else begin
                    want = nearest_expected.pop_front();
                    results_checked++;
                    if (out_bus.data.cluster_index !== want.cluster_index) begin
                        report_mismatch($sformatf("cluster_index got %0d want %0d",
                            out_bus.data.cluster_index, want.cluster_index));
                    end
                    if (out_bus.data.squared_distance !== want.squared_distance) begin
                        report_mismatch($sformatf("squared_distance got %0d want %0d",
                            out_bus.data.squared_distance, want.squared_distance));
                    end
                end
            end
        end
    end

    initial begin
        i_rst_n           = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = '0;
        cfg_data          = '0;
        in_bus.valid      = 1'b0;
        in_bus.data       = '0;
        out_bus.ready     = 1'b0;
        hold_off          = 1'b0;
        mask_reg          = MASK_RESET;
        count_reg         = COUNT_RESET;
        mismatch_count    = 0;
        load_beats        = 0;
        classify_beats    = 0;
        results_checked   = 0;
        settings_used     = 1;
        sender_idle_pct   = 30;
        receiver_idle_pct = 84;
        for (int c = 0; c < CENTROID_SLOTS; c++) begin
            for (int d = 0; d < COORD_FIELDS; d++) begin
                centroid_mem[c][d] = '0;
            end
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // every slot loaded before the first classify, at reset settings
        queue_item(OP_LOAD, 3'd0, {COORD_FIELDS{16'sh7fff}});
        queue_item(OP_LOAD, 3'd1, {COORD_FIELDS{16'sh8000}});
        queue_item(OP_LOAD, 3'd2, {COORD_FIELDS{16'sh0000}});
        queue_item(OP_LOAD, 3'd3, {16'sd100, -16'sd200, 16'sd300, -16'sd400,
                                   16'sd500, -16'sd600, 16'sd700, -16'sd800});
        queue_item(OP_LOAD, 3'd4, {16'sd100, -16'sd200, 16'sd300, -16'sd400,
                                   16'sd500, -16'sd600, 16'sd700, -16'sd800});
        queue_item(OP_LOAD, 3'd5, {(COORD_FIELDS / 2){16'sh7fff, 16'sh8000}});
        queue_item(OP_LOAD, 3'd6, {16'sd1, 16'sd2, 16'sd3, 16'sd4,
                                   16'sd5, 16'sd6, 16'sd7, 16'sd8});
        queue_item(OP_LOAD, 3'd7, {-16'sd1, -16'sd2, -16'sd3, -16'sd4,
                                   -16'sd5, -16'sd6, -16'sd7, -16'sd8});
        queue_item(OP_CLASSIFY, 3'd7, {COORD_FIELDS{16'sh7fff}});
        queue_item(OP_CLASSIFY, 3'd0, {COORD_FIELDS{16'sh8000}});
        queue_item(OP_CLASSIFY, 3'd5, {COORD_FIELDS{16'sh0000}});
        // equal centroids in slots 3 and 4: lower index must win
        queue_item(OP_CLASSIFY, 3'd4, {16'sd100, -16'sd200, 16'sd300, -16'sd400,
                                       16'sd500, -16'sd600, 16'sd700, -16'sd800});
        queue_item(OP_CLASSIFY, 3'd2, {(COORD_FIELDS / 2){16'sh7ffe, 16'sh8001}});
        queue_item(OP_CLASSIFY, 3'd6, {COORD_FIELDS{16'sh0001}});
        wait_drained();

        // one centroid only: largest possible distance
        apply_settings(8'hff, 4'd1);
        queue_item(OP_CLASSIFY, 3'd1, {COORD_FIELDS{16'sh8000}});
        wait_drained();

        // zero count behaves as one
        apply_settings(8'hff, 4'd0);
        queue_item(OP_CLASSIFY, 3'd3, {COORD_FIELDS{16'sh0000}});
        wait_drained();

        // count above the store size saturates; empty mask gives zero distance
        apply_settings(8'h00, 4'd15);
        queue_item(OP_CLASSIFY, 3'd0, make_coords(0));
        queue_item(OP_LOAD, 3'd2, {COORD_FIELDS{16'sh1234}});
        queue_item(OP_CLASSIFY, 3'd7, {COORD_FIELDS{16'sh8000}});
        wait_drained();

        // single top dimension; a load immediately followed by a classify
        apply_settings(8'h80, 4'd8);
        queue_item(OP_LOAD, 3'd6, {{(COORD_FIELDS - 1){16'sh0000}}, 16'sh4000});
        queue_item(OP_CLASSIFY, 3'd3, {{(COORD_FIELDS - 1){16'sh7fff}}, 16'sh3fff});
        wait_drained();

        run_random_phase(8'hff, 4'd8,  30, 84, 1'b0);
        run_random_phase(8'h00, 4'd3,  30, 84, 1'b0);
        run_random_phase(8'h81, 4'd1,  30, 84, 1'b0);
        run_random_phase(8'h5a, 4'd15, 84, 30, 1'b0);
        run_random_phase(8'hff, 4'd0,  84, 30, 1'b0);
        run_random_phase(8'h01, 4'd5,  84, 30, 1'b0);
        run_random_phase(8'hff, 4'd8,  0,  0,  1'b1);
        run_random_phase(MASK_W'($urandom), COUNT_W'($urandom), 0, 0, 1'b0);
        run_random_phase(8'h3c, 4'd7,  0,  0,  1'b0);

        $display("covered %0d centroid loads and %0d classify beats over %0d register settings",
                 load_beats, classify_beats, settings_used);
        $display("%0d results compared, %0d mismatches", results_checked, mismatch_count);
        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        repeat (TIMEOUT_CYCLES) @(posedge i_clk);
        $display("timeout with %0d results outstanding", nearest_expected.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule
